/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros; clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dm4_pkg.sv */
// ----------------------------------------------------------------------------
// dm4_pkg
// Types, widths and lane wiring tables for the 4x4 determinant block.
// ----------------------------------------------------------------------------
package dm4_pkg;

	localparam int ENTRY_WIDTH = 12;
	localparam int COLS        = 4;
	localparam int NUM_PAIRS   = 6;
	localparam int M2_WIDTH    = 2 * ENTRY_WIDTH + 1;
	localparam int M3_WIDTH    = 3 * ENTRY_WIDTH + 2;
	localparam int DET_WIDTH   = 4 * ENTRY_WIDTH + 2;

	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;
	typedef logic signed [M2_WIDTH-1:0]    minor2_t;
	typedef logic signed [M3_WIDTH-1:0]    minor3_t;
	typedef logic signed [DET_WIDTH-1:0]   det_t;
	typedef logic [1:0]                    col_idx_t;
	typedef logic [2:0]                    pair_idx_t;

	// row positions
	localparam logic [1:0] ROW_0 = 2'd0;
	localparam logic [1:0] ROW_1 = 2'd1;
	localparam logic [1:0] ROW_2 = 2'd2;
	localparam logic [1:0] ROW_3 = 2'd3;

	// column pairs of the 2x2 minors over rows 0 and 1:
	// (0,1) (0,2) (0,3) (1,2) (1,3) (2,3)
	localparam col_idx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam col_idx_t PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

	// 3x3 minor j drops column j; expanded along row 2 as
	// r2[p]*D(q,r) - r2[q]*D(p,r) + r2[r]*D(p,q)
	localparam col_idx_t COF_COL [COLS][3] = '{
		'{2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3},
		'{2'd0, 2'd1, 2'd2}
	};
	localparam pair_idx_t COF_MIN [COLS][3] = '{
		'{3'd5, 3'd4, 3'd3},
		'{3'd5, 3'd2, 3'd1},
		'{3'd4, 3'd2, 3'd0},
		'{3'd3, 3'd1, 3'd0}
	};

	// Laplace sign along row 3: (-1)^(3+j)
	localparam logic DET_NEG [COLS] = '{1'b1, 1'b0, 1'b1, 1'b0};

endpackage

/* sv/dm4_minor2.sv */
// ----------------------------------------------------------------------------
// dm4_minor2
// One 2x2 minor lane: r0[a]*r1[b] - r0[b]*r1[a], registered on row 1.
// ----------------------------------------------------------------------------
module dm4_minor2 (
	input  logic             clk,
	input  logic             en,
	input  dm4_pkg::entry_t  r0_a,
	input  dm4_pkg::entry_t  r0_b,
	input  dm4_pkg::entry_t  r1_a,
	input  dm4_pkg::entry_t  r1_b,
	output dm4_pkg::minor2_t minor
);
	import dm4_pkg::*;

	minor2_t prod_ab;
	minor2_t prod_ba;
	minor2_t minor_q;

	assign prod_ab = minor2_t'(r0_a) * minor2_t'(r1_b);
	assign prod_ba = minor2_t'(r0_b) * minor2_t'(r1_a);

	always_ff @(posedge clk) begin
		if (en) begin
			minor_q <= prod_ab - prod_ba;
		end
	end

	assign minor = minor_q;

endmodule

/* sv/dm4_cof3.sv */
// ----------------------------------------------------------------------------
// dm4_cof3
// One 3x3 minor lane: expands along row 2 using three stored 2x2 minors.
// ----------------------------------------------------------------------------
module dm4_cof3 (
	input  logic             clk,
	input  logic             en,
	input  dm4_pkg::entry_t  e_p,
	input  dm4_pkg::entry_t  e_q,
	input  dm4_pkg::entry_t  e_r,
	input  dm4_pkg::minor2_t m_qr,
	input  dm4_pkg::minor2_t m_pr,
	input  dm4_pkg::minor2_t m_pq,
	output dm4_pkg::minor3_t minor
);
	import dm4_pkg::*;

	minor3_t prod_p;
	minor3_t prod_q;
	minor3_t prod_r;
	minor3_t minor_q;

	assign prod_p = minor3_t'(e_p) * minor3_t'(m_qr);
	assign prod_q = minor3_t'(e_q) * minor3_t'(m_pr);
	assign prod_r = minor3_t'(e_r) * minor3_t'(m_pq);

	always_ff @(posedge clk) begin
		if (en) begin
			minor_q <= prod_p - prod_q + prod_r;
		end
	end

	assign minor = minor_q;

endmodule

/* sv/dm4_merge.sv */
// ----------------------------------------------------------------------------
// dm4_merge
// Combines row 3 with the four 3x3 minors and holds the result for output.
// ----------------------------------------------------------------------------
module dm4_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  dm4_pkg::entry_t  row3  [dm4_pkg::COLS],
	input  dm4_pkg::minor3_t minor [dm4_pkg::COLS],
	output dm4_pkg::det_t    det_value,
	output logic             out_valid,
	input  logic             out_ready
);
	import dm4_pkg::*;

	det_t sum;
	det_t prod;
	det_t det_q;
	logic valid_q;

	always_comb begin
		sum  = '0;
		prod = '0;
		for (int j = 0; j < COLS; j++) begin
			prod = det_t'(row3[j]) * det_t'(minor[j]);
			if (DET_NEG[j]) begin
				sum = sum - prod;
			end else begin
				sum = sum + prod;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			det_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign det_value = det_q;
	assign out_valid = valid_q;

endmodule

/* sv/determinant_4x4_top.sv */
// ----------------------------------------------------------------------------
// det_value is presented in the cycle after the fourth row is accepted.
// One row per cycle while in_ready is high; each row feeds
// its own registered stage (row store, 2x2 minor lanes, 3x3 minor lanes, merge).
// A row stalls only while a finished determinant waits and the last row arrives.
// Reset (arst_n low) clears the row counter and the output valid; data regs keep.
// ----------------------------------------------------------------------------
// determinant_4x4_top
// Exact 4x4 determinant by incremental minor expansion, one row per request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module determinant_4x4_top (
	input  logic            clk,
	input  logic            arst_n,
	input  dm4_pkg::entry_t col0,
	input  dm4_pkg::entry_t col1,
	input  dm4_pkg::entry_t col2,
	input  dm4_pkg::entry_t col3,
	input  logic            in_valid,
	output logic            in_ready,
	output dm4_pkg::det_t   det_value,
	output logic            out_valid,
	input  logic            out_ready
);
	import dm4_pkg::*;

	logic [1:0] row_count_q;
	logic       accept;
	entry_t     row_in [COLS];
	entry_t     row0_q [COLS];
	minor2_t    m2     [NUM_PAIRS];
	minor3_t    m3     [COLS];

	assign row_in[0] = col0;
	assign row_in[1] = col1;
	assign row_in[2] = col2;
	assign row_in[3] = col3;

	// only the closing row needs room in the output register
	assign in_ready = !(row_count_q == ROW_3 && out_valid && !out_ready);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_0;
		end else if (accept) begin
			row_count_q <= row_count_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row_count_q == ROW_0) begin
			row0_q <= row_in;
		end
	end

	for (genvar g = 0; g < NUM_PAIRS; g++) begin : g_minor2
		dm4_minor2 u_minor2 (
			.clk   (clk),
			.en    (accept && row_count_q == ROW_1),
			.r0_a  (row0_q[PAIR_A[g]]),
			.r0_b  (row0_q[PAIR_B[g]]),
			.r1_a  (row_in[PAIR_A[g]]),
			.r1_b  (row_in[PAIR_B[g]]),
			.minor (m2[g])
		);
	end

	for (genvar j = 0; j < COLS; j++) begin : g_cof3
		dm4_cof3 u_cof3 (
			.clk   (clk),
			.en    (accept && row_count_q == ROW_2),
			.e_p   (row_in[COF_COL[j][0]]),
			.e_q   (row_in[COF_COL[j][1]]),
			.e_r   (row_in[COF_COL[j][2]]),
			.m_qr  (m2[COF_MIN[j][0]]),
			.m_pr  (m2[COF_MIN[j][1]]),
			.m_pq  (m2[COF_MIN[j][2]]),
			.minor (m3[j])
		);
	end

	dm4_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && row_count_q == ROW_3),
		.row3      (row_in),
		.minor     (m3),
		.det_value (det_value),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	`AST_NEXT(a_wrap, accept && row_count_q == ROW_3, row_count_q == ROW_0 && out_valid,
		"closing row must restart the counter and present a result")
	`AST_IMPL(a_stall, !in_ready, out_valid && !out_ready && row_count_q == ROW_3,
		"input stalled without a pending result")
	`AST_IMPL(a_rise, $rose(out_valid), $past(accept && row_count_q == ROW_3),
		"result appeared without a closing row")

endmodule

/* dv/determinant_4x4_top_test.sv */
// ----------------------------------------------------------------------------
// determinant_4x4_top_test
// Streams 4x4 matrices into the determinant block one row per request.
// Each finished matrix is predicted by a permutation sum, and the predictions
// are compared in order with det_value. Directed extreme matrices come first,
// then random matrices under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module determinant_4x4_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dm4_pkg::*;

	logic   clk = 1'b0;
	logic   arst_n;
	entry_t col0, col1, col2, col3;
	logic   in_valid;
	logic   in_ready;
	det_t   det_value;
	logic   out_valid;
	logic   out_ready;

	int     send_idle_pct;
	int     recv_idle_pct;
	int     mismatch_count;

	// rows of the matrix currently being sent, as accepted by the block
	entry_t accepted_rows [4][4];
	int     rows_accepted;
	det_t   det_expected [$];

	// scratch matrix used by the stimulus tasks
	entry_t mat [4][4];

	determinant_4x4_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.col0      (col0),
		.col1      (col1),
		.col2      (col2),
		.col3      (col3),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.det_value (det_value),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Sum over all permutations of the columns, sign from the inversion count.
	function automatic longint permutation_det(input entry_t m [4][4]);
		longint sum;
		longint prod;
		int     inv;
		int     p [4];
		sum = 0;
		for (int a = 0; a < 4; a++)
			for (int b = 0; b < 4; b++)
				for (int c = 0; c < 4; c++)
					for (int d = 0; d < 4; d++) begin
						if (a != b && a != c && a != d && b != c && b != d && c != d) begin
							p[0] = a; p[1] = b; p[2] = c; p[3] = d;
							inv = 0;
							for (int i = 0; i < 4; i++)
								for (int j = i + 1; j < 4; j++)
									if (p[i] > p[j])
										inv++;
							prod = longint'(m[0][a]) * longint'(m[1][b]);
							prod = prod * longint'(m[2][c]) * longint'(m[3][d]);
							if (inv % 2 == 0)
								sum += prod;
							else
								sum -= prod;
						end
					end
		return sum;
	endfunction

	// Drive one row; returns at the falling edge after it was accepted.
	task automatic send_row(input entry_t e0, input entry_t e1, input entry_t e2,
	                        input entry_t e3);
		longint d;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		col0 = e0;
		col1 = e1;
		col2 = e2;
		col3 = e3;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		accepted_rows[rows_accepted] = '{e0, e1, e2, e3};
		rows_accepted++;
		if (rows_accepted == 4) begin
			d = permutation_det(accepted_rows);
			det_expected.push_back(det_t'(d));
			rows_accepted = 0;
		end
		@(negedge clk);
	endtask

	task automatic send_matrix();
		for (int r = 0; r < 4; r++)
			send_row(mat[r][0], mat[r][1], mat[r][2], mat[r][3]);
	endtask

	task automatic set_row(input int r, input int a, input int b, input int c,
	                       input int d);
		mat[r] = '{entry_t'(a), entry_t'(b), entry_t'(c), entry_t'(d)};
	endtask

	function automatic entry_t rand_entry();
		int pick;
		entry_t e;
		pick = $urandom_range(7);
		case (pick)
			0: e = -12'sd2048;
			1: e = 12'sd2047;
			2: e = entry_t'(int'($urandom_range(8)) - 4);
			default: e = entry_t'($urandom_range(4095));
		endcase
		return e;
	endfunction

	// Result checker: compares each accepted det_value with the oldest prediction.
	always @(posedge clk) begin
		det_t want;
		if (arst_n && out_valid && out_ready) begin
			if (det_expected.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected det_value, expected none, actual %0d",
				         $realtime, det_value);
			end else begin
				want = det_expected.pop_front();
				if (det_value !== want) begin
					mismatch_count++;
					$display("%0t: det_value mismatch, expected %0d, actual %0d",
					         $realtime, want, det_value);
				end
			end
		end
	end

	always @(negedge clk)
		out_ready = ($urandom_range(99) >= recv_idle_pct);

	task automatic test_directed_matrices();
		// identity
		set_row(0, 1, 0, 0, 0);
		set_row(1, 0, 1, 0, 0);
		set_row(2, 0, 0, 1, 0);
		set_row(3, 0, 0, 0, 1);
		send_matrix();
		// all most negative: singular
		for (int r = 0; r < 4; r++)
			set_row(r, -2048, -2048, -2048, -2048);
		send_matrix();
		// diagonal of most negative entries: largest positive product
		set_row(0, -2048, 0, 0, 0);
		set_row(1, 0, -2048, 0, 0);
		set_row(2, 0, 0, -2048, 0);
		set_row(3, 0, 0, 0, -2048);
		send_matrix();
		// Hadamard pattern of both extremes: near the largest magnitude
		set_row(0, -2048, -2048, -2048, -2048);
		set_row(1, -2048, 2047, -2048, 2047);
		set_row(2, -2048, -2048, 2047, 2047);
		set_row(3, -2048, 2047, 2047, -2048);
		send_matrix();
		// odd permutation of a mixed diagonal: negative sign
		set_row(0, 0, -2048, 0, 0);
		set_row(1, 2047, 0, 0, 0);
		set_row(2, 0, 0, 2047, 0);
		set_row(3, 0, 0, 0, -2048);
		send_matrix();
		// upper triangular with extreme fill above the diagonal
		set_row(0, 2047, -2048, 2047, -1);
		set_row(1, 0, 2047, -2048, 2047);
		set_row(2, 0, 0, -2048, -2048);
		set_row(3, 0, 0, 0, -2048);
		send_matrix();
	endtask

	task automatic send_random_matrices(input int count);
		int kind;
		for (int n = 0; n < count; n++) begin
			kind = $urandom_range(7);
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					case (kind)
						0: mat[r][c] = ($urandom_range(1) != 0) ? 12'sd2047 : -12'sd2048;
						1: mat[r][c] = entry_t'(int'($urandom_range(8)) - 4);
						default: mat[r][c] = rand_entry();
					endcase
			// singular matrix from a repeated row
			if (kind == 2)
				mat[3] = mat[$urandom_range(2)];
			send_matrix();
		end
	endtask

	task automatic test_slow_receiver();
		send_idle_pct = 6;
		recv_idle_pct = 67;
		send_random_matrices(66);
	endtask

	task automatic test_slow_sender();
		send_idle_pct = 67;
		recv_idle_pct = 6;
		send_random_matrices(66);
	endtask

	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_matrices(68);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		col0 = '0;
		col1 = '0;
		col2 = '0;
		col3 = '0;
		out_ready = 1'b0;
		send_idle_pct = 6;
		recv_idle_pct = 67;
		mismatch_count = 0;
		rows_accepted = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_matrices();
		test_slow_receiver();
		test_slow_sender();
		test_full_rate();
		in_valid = 1'b0;

		while (det_expected.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && det_expected.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
